// ----- rtl/assert_macros.svh -----
// Assertion shorthands shared by the RTL of the heap unit.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bmh_pkg.sv -----
// Shared types and constants for the binary min-heap unit.
// No dependencies; used by bmh_ctrl, bmh_dpath and binary_min_heap_unit.
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int KEY_W      = 32;
  localparam int CNT_HELD_W = 7;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic                    full_drop;
    logic                    empty_pop;
    logic [CNT_HELD_W-1:0]   count_held;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // take the input beat, start the item
    logic pop_load;  // capture root and last entry after a pop
    logic up_read;   // sift up: fetch parent (or finish at root)
    logic up_cmp;    // sift up: compare and move
    logic dn_read;   // sift down: fetch both children (or finish at leaf)
    logic dn_cmp;    // sift down: compare and move
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic count_zero;
    logic at_root;
    logic no_child;
    logic up_move;
    logic dn_move;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/bmh_dpath.sv -----
// Datapath of the heap unit: key store, sift position, held key, count, result register.
// Depends on bmh_pkg and assert_macros.svh; driven by bmh_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmh_dpath #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  bmh_pkg::in_item_t  item,
  input  bmh_pkg::ctrl_cmd_t cmd,
  output bmh_pkg::dp_status_t st,
  output logic               result_valid,
  input  logic               result_ready,
  output bmh_pkg::out_item_t result
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int LW = AW + 2;  // room for 2*pos+2

  logic signed [bmh_pkg::KEY_W-1:0] mem [HEAP_DEPTH];
  logic signed [bmh_pkg::KEY_W-1:0] rd_a, rd_b;
  logic signed [bmh_pkg::KEY_W-1:0] hold;
  logic signed [bmh_pkg::KEY_W-1:0] key_res;
  logic signed [bmh_pkg::KEY_W-1:0] pick_key;
  logic signed [bmh_pkg::KEY_W-1:0] wdata;
  logic                             full_r, empty_r;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    cnt_m1;
  logic [CW+bmh_pkg::CNT_HELD_W-1:0] cnt_wide;
  logic [AW-1:0]                    pos, parent, ra, rb, waddr;
  logic [LW-1:0]                    pos_ext, cnt_ext, lchild, rchild, pick_idx;
  logic                             r_ok, pick_right, we;

  assign pos_ext  = LW'(pos);
  assign cnt_ext  = LW'(count);
  assign lchild   = (pos_ext << 1) + LW'(1);
  assign rchild   = lchild + LW'(1);
  assign parent   = (pos - AW'(1)) >> 1;
  assign cnt_m1   = count - CW'(1);
  assign r_ok     = rchild < cnt_ext;
  // left child wins ties
  assign pick_right = r_ok && (rd_b < rd_a);
  assign pick_key   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? rchild : lchild;

  always_comb begin
    st.is_push    = (item.mode == bmh_pkg::MODE_PUSH);
    st.full       = (count == CW'(HEAP_DEPTH));
    st.empty      = (count == '0);
    st.count_zero = (count == '0);
    st.at_root    = (pos == '0);
    st.no_child   = (lchild >= cnt_ext);
    st.up_move    = (hold < rd_a);
    st.dn_move    = (pick_key < hold);
    st.out_free   = !result_valid || result_ready;
  end

  // read addresses: idle default fetches root and last entry for a pop
  always_comb begin
    ra = '0;
    rb = cnt_m1[AW-1:0];
    if (cmd.up_read) begin
      ra = parent;
    end else if (cmd.dn_read) begin
      ra = lchild[AW-1:0];
      rb = rchild[AW-1:0];
    end
  end

  // single write port: either a moved key or the held key at its final slot
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = hold;
    if (cmd.up_read && st.at_root) begin
      we = 1'b1;
    end else if (cmd.up_cmp) begin
      we = 1'b1;
      if (st.up_move) begin
        wdata = rd_a;
      end
    end else if (cmd.dn_read && st.no_child) begin
      we = 1'b1;
    end else if (cmd.dn_cmp) begin
      we = 1'b1;
      if (st.dn_move) begin
        wdata = pick_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      full_r  <= st.is_push && st.full;
      empty_r <= !st.is_push && st.empty;
      key_res <= '0;
      if (st.is_push && !st.full) begin
        hold <= item.key_in;
        pos  <= count[AW-1:0];
      end else if (!st.is_push && !st.empty) begin
        pos <= '0;
      end
    end
    if (cmd.pop_load) begin
      key_res <= rd_a;
      hold    <= rd_b;
    end
    if (cmd.up_cmp && st.up_move) begin
      pos <= parent;
    end
    if (cmd.dn_cmp && st.dn_move) begin
      pos <= pick_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      if (st.is_push && !st.full) begin
        count <= count + CW'(1);
      end else if (!st.is_push && !st.empty) begin
        count <= cnt_m1;
      end
    end
  end

  assign cnt_wide = (CW + bmh_pkg::CNT_HELD_W)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.key_out    <= key_res;
      result.full_drop  <= full_r;
      result.empty_pop  <= empty_r;
      result.count_held <= cnt_wide[bmh_pkg::CNT_HELD_W-1:0];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(HEAP_DEPTH), "entry count above depth")
  `ASSERT_IMPLY(a_dn_pos, cmd.dn_read, LW'(pos) < cnt_ext, "sift down past last entry")
  `ASSERT_IMPLY(a_up_pos, cmd.up_cmp, pos != '0, "sift up compare at root")

endmodule

// ----- rtl/bmh_ctrl.sv -----
// Sequencer of the heap unit: one-hot FSM that steps push/pop sifts.
// Depends on bmh_pkg and assert_macros.svh; commands bmh_dpath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  bmh_pkg::dp_status_t st,
  output bmh_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POP_LD = 7'b0000010,
    S_UP_RD  = 7'b0000100,
    S_UP_CMP = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = item_valid;
        if (item_valid) begin
          if (st.is_push) begin
            state_next = st.full ? S_RESULT : S_UP_RD;
          end else begin
            state_next = st.empty ? S_RESULT : S_POP_LD;
          end
        end
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_next   = st.count_zero ? S_RESULT : S_DN_RD;
      end
      S_UP_RD: begin
        cmd.up_read = 1'b1;
        state_next  = st.at_root ? S_RESULT : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = st.up_move ? S_UP_RD : S_RESULT;
      end
      S_DN_RD: begin
        cmd.dn_read = 1'b1;
        state_next  = st.no_child ? S_RESULT : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_next = st.dn_move ? S_DN_RD : S_RESULT;
      end
      S_RESULT: begin
        cmd.load_out = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_ALWAYS(a_state_onehot, $onehot(state), "state not one-hot")
  `ASSERT_NEXT(a_accept_busy, item_valid && item_ready, state != S_IDLE, "accept did not start work")
  `ASSERT_NEXT(a_pop_sift, state == S_POP_LD && !st.count_zero, state == S_DN_RD, "pop skipped sift down")

endmodule

// ----- rtl/binary_min_heap_unit.sv -----
// Binary min-heap priority queue of signed 32-bit keys, HEAP_DEPTH entries deep.
// Each input beat (mode 0 push key_in, mode 1 pop) yields exactly one result beat
// carrying the popped minimum (zero on push), the full-drop and empty-pop flags,
// and the count held afterwards (low 7 bits). One item is worked at a time: a
// dropped push or empty pop goes straight to the result; a push sifts the new key
// up level by level from the first free slot, and a pop moves the last entry to
// the root and sifts it down level by level until it stops or reaches a leaf (a
// pop that takes the last key does no sift). Each level is one registered read
// and one compare/write on the key store.
// Depends on bmh_pkg, bmh_ctrl and bmh_dpath.
`timescale 1ns / 1ps

module binary_min_heap_unit #(
  parameter int HEAP_DEPTH = 64  // 2 .. 65536
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               item_valid,
  output logic               item_ready,
  input  bmh_pkg::in_item_t  item,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output bmh_pkg::out_item_t result
);

  bmh_pkg::ctrl_cmd_t  cmd;  // per-cycle datapath operation
  bmh_pkg::dp_status_t st;   // compare results, bounds, output slot state

  // FSM: idle -> (pop load) -> sift up or sift down loop -> result
  bmh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // Key store with two registered read ports and one write port; the key being
  // sifted stays in a register and is written once at its final slot. The
  // result register lets the next beat be taken while a result waits.
  bmh_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
